// File: hdl/ffba_pkg.sv
// ffba_pkg: shared types, codes and sizing constants of the first-fit block allocator.
// No dependencies. Used by the allocator top level and its checker.

package ffba_pkg;

    // Default arena size in 16-byte granules
    localparam int HEAP_GRANULES_DEF = 4096;

    // Width of the arena limit register, block lengths and the carve point
    localparam int GRAN_W = 13;

    // Width of the walk position; the step past the last header may exceed GRAN_W bits
    localparam int WALK_W = GRAN_W + 1;

    // Reset value of the arena limit register
    localparam logic [GRAN_W-1:0] ARENA_RESET = GRAN_W'(4096);

    // Command codes
    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ALLOC    = 2'd0,
        ST_FREED    = 2'd1,
        ST_NOSPACE  = 2'd2,
        ST_NULLFREE = 2'd3
    } status_t;

    // One block header: free mark and block length in granules
    typedef struct packed {
        logic              free_mark;
        logic [GRAN_W-1:0] len;
    } hdr_t;

endpackage

// File: hdl/first_fit_block_allocator.sv
// first_fit_block_allocator: first-fit allocator over an arena of 16-byte granules.
// Depends on ffba_pkg. Header store is a one-port-write, one-port-read synchronous RAM.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  request | req_valid, req_stall, cmd, req_size,     | in
//          | free_addr                                |
//  result  | rsp_valid, rsp_stall, user_addr, status  | out
//  config  | cfg_wr_en, cfg_wr_data                   | in
//
// One request is worked on at a time. A null or stray free goes straight to the result;
// any other free reads its header and writes it back with the free mark set. An allocate
// walks the headers and reuses a block whole, splits it and writes the tail header, or
// carves a new block: the header RAM gives one header per cycle, and split and carve
// writes share its write port. Reset clears control state and the carve point and sets the
// limit register to its default; the header RAM is not cleared and needs no sweep. A
// finished result waits in a holding state while the output register is full and stalled;
// the request side stays stalled until the result has moved into the output register.

module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int HEAP_GRANULES = HEAP_GRANULES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_wr_en,
    input  logic [GRAN_W-1:0] cfg_wr_data,

    input  logic              req_valid,
    output logic              req_stall,
    input  logic              cmd,
    input  logic [15:0]       req_size,
    input  logic [15:0]       free_addr,

    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [15:0]       user_addr,
    output logic [1:0]        status
);

    localparam int AW = $clog2(HEAP_GRANULES);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WALK  = 6'b000010,
        S_TAIL  = 6'b000100,
        S_CARVE = 6'b001000,
        S_FREE  = 6'b010000,
        S_POST  = 6'b100000
    } state_t;

    state_t            state_reg,  state_next;
    logic [GRAN_W-1:0] arena_reg;
    logic [GRAN_W-1:0] carve_reg,  carve_next;
    logic [WALK_W-1:0] g_reg,      g_next;
    logic [GRAN_W-1:0] need_reg,   need_next;
    logic [GRAN_W-1:0] len_reg,    len_next;
    logic [15:0]       res_addr_reg, res_addr_next;
    status_t           res_status_reg, res_status_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [15:0]       user_addr_reg, user_addr_next;
    status_t           status_reg, status_next;

    // Header RAM
    hdr_t              hdr_mem [HEAP_GRANULES];
    hdr_t              rd_data_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    hdr_t              wr_data;

    // Derived values
    logic [GRAN_W-1:0] lim;
    logic [16:0]       need_sum;
    logic [GRAN_W-1:0] req_need;
    logic [11:0]       free_gran;
    logic              free_in_store;
    logic              hit;
    logic              split;
    logic [WALK_W-1:0] tail_g;
    logic              tail_in_store;
    logic [WALK_W-1:0] step_g;
    logic [WALK_W-1:0] carve_end;
    logic              carve_fits;
    logic [WALK_W-1:0] g_inc;
    logic [GRAN_W-1:0] carve_inc;
    logic              rsp_free;

    // Arena limit clamped to [2, HEAP_GRANULES]
    always_comb
    begin
        lim = arena_reg;
        if (32'(arena_reg) > 32'(HEAP_GRANULES))
        begin
            lim = GRAN_W'(HEAP_GRANULES);
        end
        if (lim < GRAN_W'(2))
        begin
            lim = GRAN_W'(2);
        end
    end

    // Granules needed: payload plus header, rounded up
    assign need_sum = {1'b0, req_size} + 17'd31;
    assign req_need = need_sum[16:4];

    // Header granule of a free
    assign free_gran     = free_addr[15:4] - 12'd1;
    assign free_in_store = 32'(free_gran) < 32'(HEAP_GRANULES);

    // Walk evaluation on the header just read
    assign hit           = rd_data_reg.free_mark && (rd_data_reg.len >= need_reg);
    assign split         = {1'b0, rd_data_reg.len} >= ({1'b0, need_reg} + WALK_W'(2));
    assign tail_g        = g_reg + {1'b0, need_reg};
    assign tail_in_store = 32'(tail_g) < 32'(HEAP_GRANULES);
    assign step_g        = g_reg + ((rd_data_reg.len == '0) ? WALK_W'(1)
                                                            : {1'b0, rd_data_reg.len});

    // Carve check
    assign carve_end  = {1'b0, carve_reg} + {1'b0, need_reg};
    assign carve_fits = carve_end <= {1'b0, lim};

    assign g_inc     = g_reg + WALK_W'(1);
    assign carve_inc = carve_reg + GRAN_W'(1);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        carve_next      = carve_reg;
        g_next          = g_reg;
        need_next       = need_reg;
        len_next        = len_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        user_addr_next  = user_addr_reg;
        status_next     = status_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_addr_next = '0;
                    if (cmd == CMD_FREE)
                    begin
                        if (free_addr == '0)
                        begin
                            res_status_next = ST_NULLFREE;
                            state_next      = S_POST;
                        end
                        else if ((free_addr[15:4] != '0) && free_in_store)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(free_gran);
                            g_next     = WALK_W'(free_gran);
                            state_next = S_FREE;
                        end
                        else
                        begin
                            res_status_next = ST_FREED;
                            state_next      = S_POST;
                        end
                    end
                    else
                    begin
                        need_next = req_need;
                        g_next    = '0;
                        if (carve_reg != '0)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = S_WALK;
                        end
                        else
                        begin
                            state_next = S_CARVE;
                        end
                    end
                end
            end

            S_WALK:
            begin
                if (hit)
                begin
                    wr_en             = 1'b1;
                    wr_addr           = AW'(g_reg);
                    wr_data.free_mark = 1'b0;
                    wr_data.len       = split ? need_reg : rd_data_reg.len;
                    res_addr_next     = {g_inc[11:0], 4'b0000};
                    res_status_next   = ST_ALLOC;
                    if (split && tail_in_store)
                    begin
                        g_next     = tail_g;
                        len_next   = rd_data_reg.len - need_reg;
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        state_next = S_POST;
                    end
                end
                else if ((step_g < {1'b0, lim}) && (step_g < {1'b0, carve_reg}))
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(step_g);
                    g_next  = step_g;
                end
                else
                begin
                    state_next = S_CARVE;
                end
            end

            S_TAIL:
            begin
                wr_en             = 1'b1;
                wr_addr           = AW'(g_reg);
                wr_data.free_mark = 1'b1;
                wr_data.len       = len_reg;
                state_next        = S_POST;
            end

            S_CARVE:
            begin
                if (carve_fits)
                begin
                    wr_en             = 1'b1;
                    wr_addr           = AW'(carve_reg);
                    wr_data.free_mark = 1'b0;
                    wr_data.len       = need_reg;
                    carve_next        = carve_end[GRAN_W-1:0];
                    res_addr_next     = {carve_inc[11:0], 4'b0000};
                    res_status_next   = ST_ALLOC;
                end
                else
                begin
                    res_addr_next   = '0;
                    res_status_next = ST_NOSPACE;
                end
                state_next = S_POST;
            end

            S_FREE:
            begin
                // Set the free mark, keep the length
                wr_en             = 1'b1;
                wr_addr           = AW'(g_reg);
                wr_data.free_mark = 1'b1;
                wr_data.len       = rd_data_reg.len;
                res_status_next   = ST_FREED;
                state_next        = S_POST;
            end

            S_POST:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    user_addr_next = res_addr_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            arena_reg     <= ARENA_RESET;
            carve_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            carve_reg     <= carve_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                arena_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        g_reg          <= g_next;
        need_reg       <= need_next;
        len_reg        <= len_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        user_addr_reg  <= user_addr_next;
        status_reg     <= status_next;
    end

    // Header RAM write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hdr_mem[wr_addr] <= wr_data;
        end
    end

    // Header RAM read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= hdr_mem[rd_addr];
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign user_addr = user_addr_reg;
    assign status    = status_reg;

endmodule

// File: hdl/ffba_checker.sv
// ffba_checker: port-level assertions for the first-fit block allocator.
// Depends on ffba_pkg; attached to first_fit_block_allocator by the bind below.

module ffba_checker
    import ffba_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_wr_en,
    input logic [GRAN_W-1:0] cfg_wr_data,
    input logic              req_valid,
    input logic              req_stall,
    input logic              cmd,
    input logic [15:0]       req_size,
    input logic [15:0]       free_addr,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input logic [15:0]       user_addr,
    input logic [1:0]        status
);

    // A stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(user_addr) && $stable(status))
        else $error("stalled result beat changed");

    // Only an allocation carries an address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_ALLOC) |-> user_addr == '0)
        else $error("address on a non-allocation result");

    // Payload addresses sit on granule boundaries
    a_addr_align: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_ALLOC) |-> user_addr[3:0] == 4'b0000)
        else $error("unaligned payload address");

    // One request at a time: the request side stalls after a beat
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second request taken while busy");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
